FILE: hdl/plerp_pkg.sv
// Package for the interpolated palette colour map.
// Holds the palette geometry, the stream payload layout and the palette access struct.
// No dependencies.
package plerp_pkg;

    localparam int PAL_ENTRIES = 257;
    localparam int PAL_AW      = $clog2(PAL_ENTRIES);

    localparam int PIX_W    = 16;
    localparam int ADDR_W   = 9;
    localparam int COLOUR_W = 32;

    localparam int S_DATA_BITS = PIX_W + ADDR_W + COLOUR_W;
    localparam int S_DATA_W    = ((S_DATA_BITS + 7) / 8) * 8;
    localparam int M_DATA_W    = COLOUR_W;

    localparam logic CMD_MAP   = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef struct packed {
        logic                rd_en;
        logic [ADDR_W-1:0]   rd_lo_idx;
        logic [ADDR_W-1:0]   rd_hi_idx;
        logic                wr_en;
        logic [ADDR_W-1:0]   wr_addr;
        logic [COLOUR_W-1:0] wr_data;
    } t_pal_req;

endpackage

FILE: hdl/plerp_palette.sv
// Palette memory: one write port and two registered read ports.
// Out-of-range writes are dropped and out-of-range reads go to the last entry.
// Depends on plerp_pkg.
module plerp_palette import plerp_pkg::*; (
    input  logic                i_clk,
    input  t_pal_req            i_req,
    output logic [COLOUR_W-1:0] o_lo,
    output logic [COLOUR_W-1:0] o_hi
);

    logic [COLOUR_W-1:0] r_mem [PAL_ENTRIES];
    logic [COLOUR_W-1:0] r_lo;
    logic [COLOUR_W-1:0] r_hi;
    logic [PAL_AW-1:0]   lo_addr;
    logic [PAL_AW-1:0]   hi_addr;
    logic [PAL_AW-1:0]   wr_addr;
    logic                wr_ok;

    always_comb begin
        if (32'(i_req.rd_lo_idx) < PAL_ENTRIES) begin
            lo_addr = PAL_AW'(i_req.rd_lo_idx);
        end else begin
            lo_addr = PAL_AW'(PAL_ENTRIES - 1);
        end
        if (32'(i_req.rd_hi_idx) < PAL_ENTRIES) begin
            hi_addr = PAL_AW'(i_req.rd_hi_idx);
        end else begin
            hi_addr = PAL_AW'(PAL_ENTRIES - 1);
        end
        wr_ok   = i_req.wr_en && (32'(i_req.wr_addr) < PAL_ENTRIES);
        wr_addr = PAL_AW'(i_req.wr_addr);
    end

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[wr_addr] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_lo <= r_mem[lo_addr];
            r_hi <= r_mem[hi_addr];
        end
    end

    assign o_lo = r_lo;
    assign o_hi = r_hi;

endmodule

FILE: hdl/palette_lerp_colour_map_top.sv
// A map word passes the palette read registers and then the blended-colour register on its way to the output.
// Throughput: one word per cycle while the output is not stalled; the two palette reads are done in the same cycle.
// A result waiting at the output blocks the next word only when the palette read stage also holds a word.
// Palette write words are written to the palette and give no result.
// Reset (i_rst_n low, synchronous) empties the pipeline; the palette is not cleared.
module palette_lerp_colour_map_top import plerp_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    // Fields from bit 0: pixel_value[15:0], entry_address[24:16],
    // entry_colour[56:25], zero padding.
    input  logic [S_DATA_W-1:0] i_s_tdata,
    // Fields from bit 0: cmd.
    input  logic                i_s_tuser,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // Fields from bit 0: colour[31:0].
    output logic [M_DATA_W-1:0] o_m_tdata
);

    function automatic logic [COLOUR_W-1:0] blend(input logic [COLOUR_W-1:0] lo,
                                                  input logic [COLOUR_W-1:0] hi,
                                                  input logic [7:0]          frac);
        logic [COLOUR_W-1:0] res;
        logic signed [8:0]   diff;
        logic signed [17:0]  prod;
        logic signed [17:0]  sum;
        res = '0;
        for (int lane = 0; lane < COLOUR_W / 8; lane++) begin
            diff = $signed({1'b0, hi[lane*8 +: 8]}) - $signed({1'b0, lo[lane*8 +: 8]});
            prod = 18'(diff * $signed({1'b0, frac}));
            sum  = $signed({2'b00, lo[lane*8 +: 8], 8'h00}) + prod;
            res[lane*8 +: 8] = sum[15:8];
        end
        return res;
    endfunction

    logic [PIX_W-1:0]    in_pix;
    logic [ADDR_W-1:0]   in_addr;
    logic [COLOUR_W-1:0] in_colour;
    logic                accept;
    logic                accept_map;
    logic                move1;
    t_pal_req            pal_req;
    logic [COLOUR_W-1:0] pal_lo;
    logic [COLOUR_W-1:0] pal_hi;

    logic                r_v1;
    logic                n_v1;
    logic [7:0]          r_frac;
    logic                r_v2;
    logic                n_v2;
    logic [COLOUR_W-1:0] r_colour;

    assign in_pix    = i_s_tdata[PIX_W-1:0];
    assign in_addr   = i_s_tdata[PIX_W +: ADDR_W];
    assign in_colour = i_s_tdata[PIX_W + ADDR_W +: COLOUR_W];

    assign move1      = !r_v2 || i_m_tready;
    assign o_s_tready = !r_v1 || move1;
    assign accept     = i_s_tvalid && o_s_tready;
    assign accept_map = accept && (i_s_tuser == CMD_MAP);

    always_comb begin
        pal_req.rd_en     = accept_map;
        pal_req.rd_lo_idx = {1'b0, in_pix[15:8]};
        pal_req.rd_hi_idx = {1'b0, in_pix[15:8]} + 9'd1;
        pal_req.wr_en     = accept && (i_s_tuser == CMD_WRITE);
        pal_req.wr_addr   = in_addr;
        pal_req.wr_data   = in_colour;
    end

    plerp_palette u_palette (
        .i_clk (i_clk),
        .i_req (pal_req),
        .o_lo  (pal_lo),
        .o_hi  (pal_hi)
    );

    always_comb begin
        if (accept_map) begin
            n_v1 = 1'b1;
        end else if (move1) begin
            n_v1 = 1'b0;
        end else begin
            n_v1 = r_v1;
        end
        if (move1) begin
            n_v2 = r_v1;
        end else begin
            n_v2 = r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_map) begin
            r_frac <= in_pix[7:0];
        end
        if (move1 && r_v1) begin
            r_colour <= blend(pal_lo, pal_hi, r_frac);
        end
    end

    assign o_m_tvalid = r_v2;
    assign o_m_tdata  = r_colour;

endmodule

FILE: hdl/plerp_checker.sv
// Port-level checker for the interpolated palette colour map, bound to the top level.
// Depends on plerp_pkg and palette_lerp_colour_map_top.
module plerp_checker import plerp_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_s_tvalid,
    input logic                o_s_tready,
    input logic                i_s_tuser,
    input logic                o_m_tvalid,
    input logic                i_m_tready,
    input logic [M_DATA_W-1:0] o_m_tdata
);

    // An empty output stage always leaves room for a new word.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled while output stage is empty");

    // A map word taken with the output empty reaches the output through the palette read and colour registers.
    a_map_reaches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && (i_s_tuser == CMD_MAP) && !o_m_tvalid)
        |-> ##2 o_m_tvalid)
        else $error("map word did not reach the output");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled output word changed");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

bind palette_lerp_colour_map_top plerp_checker u_plerp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
